FILE: sv/sps_pkg.sv
// Shared types, constants and helper functions for the stepper phase sequencer.
// Depends on nothing; every other file of the block uses it by scoped names.
package sps_pkg;

    // Input clock frequency that the step rate is divided from
    localparam int unsigned CLOCK_HZ = 16000000;

    // Quotient width of CLOCK_HZ / rate, and the divider's step counter width
    localparam int CLK_W = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W = $clog2(CLK_W + 1);

    localparam int RATE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int PSC_W   = 10;
    localparam int PADDR_W = 3;

    // Request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_RUN  = 2'd2;
    localparam logic [1:0] REQ_STOP = 2'd3;

    // Register index carried in paddr[2]
    localparam logic REG_HALF_STEP = 1'b0;

    // Coil drive tables
    localparam logic [3:0] HALF_TABLE [0:7] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [3:0] FULL_TABLE [0:3] = '{4'h9, 4'hC, 4'h6, 4'h3};

    // Prescaler shifts; every prescaler is a power of two
    localparam logic [3:0] PSC_SHIFT [0:6] = '{4'd0, 4'd3, 4'd5, 4'd6,
                                               4'd7, 4'd8, 4'd10};

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               direction;
        logic [COUNT_W-1:0] step_count;
        logic [RATE_W-1:0]  step_rate;
        logic               free_coils;
    } req_t;

    typedef struct packed {
        logic [3:0]         coil_pattern;
        logic               accepted;
        logic               running;
        logic [COUNT_W-1:0] steps_to_go;
        logic               step_taken;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic apply;        // tick, stop or zero-count start, applied without the divider
        logic start_begin;  // latch a start and launch the divider
        logic start_finish; // pick the prescaler and arm the timer
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_div;
        logic div_done;
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] sel;
        logic [7:0] cmp;
    } pick_t;

    // Prescaler ratio for a select code
    function automatic logic [PSC_W:0] psc_ratio(input logic [2:0] sel);
        logic [PSC_W:0] r;
        case (sel)
            3'd0:    r = (PSC_W+1)'(1);
            3'd1:    r = (PSC_W+1)'(8);
            3'd2:    r = (PSC_W+1)'(32);
            3'd3:    r = (PSC_W+1)'(64);
            3'd4:    r = (PSC_W+1)'(128);
            3'd5:    r = (PSC_W+1)'(256);
            default: r = (PSC_W+1)'(1024);
        endcase
        return r;
    endfunction

    // First prescaler whose count CLOCK_HZ / (prescaler * rate) lies in 2..256.
    // floor(floor(a/b)/2^s) equals floor(a/(b*2^s)), so one quotient serves all.
    function automatic pick_t pick_rate(input logic [CLK_W-1:0] quo,
                                        input logic rate_zero);
        pick_t          p;
        logic [CLK_W-1:0] c;
        p = '0;
        for (int k = 6; k >= 0; k--) begin
            c = quo >> PSC_SHIFT[k];
            if (c >= CLK_W'(2) && c <= CLK_W'(256)) begin
                p.ok  = 1'b1;
                p.sel = 3'(k);
                p.cmp = 8'(c - CLK_W'(1));
            end
        end
        if (rate_zero) begin
            p.ok = 1'b0;
        end
        return p;
    endfunction

endpackage

FILE: sv/sps_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sps_pkg for the payload types.
interface sps_req_if;
    logic          valid;
    logic          ready;
    sps_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sps_rsp_if;
    logic          valid;
    logic          ready;
    sps_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/sps_div.sv
// Bit-serial restoring divider: CLOCK_HZ / rate, one quotient bit a cycle.
// Depends on sps_pkg for widths and the clock constant.
module sps_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sps_pkg::RATE_W-1:0]    rate,
    output logic [sps_pkg::CLK_W-1:0]     quotient,
    output logic                          done
);

    logic [sps_pkg::RATE_W:0]   rem_reg, rem_next;
    logic [sps_pkg::CLK_W-1:0]  quo_reg, quo_next;
    logic [sps_pkg::RATE_W-1:0] den_reg, den_next;
    logic [sps_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [sps_pkg::RATE_W:0]   shifted;
    logic [sps_pkg::RATE_W+1:0] trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        shifted   = {rem_reg[sps_pkg::RATE_W-1:0], quo_reg[sps_pkg::CLK_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = sps_pkg::CLK_W'(sps_pkg::CLOCK_HZ);
            den_next  = rate;
            cnt_next  = sps_pkg::CNT_W'(sps_pkg::CLK_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!trial[sps_pkg::RATE_W+1]) begin
                rem_next = trial[sps_pkg::RATE_W:0];
                quo_next = {quo_reg[sps_pkg::CLK_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[sps_pkg::CLK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - sps_pkg::CNT_W'(1);
            if (cnt_reg == sps_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: sv/sps_ctrl.sv
// Controller: handshakes and the wait for the divider on start commands.
// Depends on sps_pkg for the state, command and status types.
module sps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  sps_pkg::status_t  status,
    output sps_pkg::cmd_t     cmd
);

    sps_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;
    logic            load_out;

    // Result slot is free when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            sps_pkg::ST_IDLE:
            begin
                in_ready = slot_free;
                if (in_valid && slot_free) begin
                    if (status.needs_div) begin
                        cmd.start_begin = 1'b1;
                        state_next      = sps_pkg::ST_DIVIDE;
                    end else begin
                        cmd.apply = 1'b1;
                        load_out  = 1'b1;
                    end
                end
            end
            sps_pkg::ST_DIVIDE:
            begin
                if (status.div_done && slot_free) begin
                    cmd.start_finish = 1'b1;
                    load_out         = 1'b1;
                    state_next       = sps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sps_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= sps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/sps_datapath.sv
// Datapath: phase, timer and move state, the divider and the result register.
// Depends on sps_pkg and instantiates sps_div.
module sps_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sps_pkg::cmd_t     cmd,
    input  sps_pkg::req_t     req,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    output logic              half_step_mode,
    output sps_pkg::status_t  status,
    output sps_pkg::rsp_t     rsp
);

    logic                        half_reg, half_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [3:0]                  coil_reg, coil_next;
    logic                        run_reg, run_next;
    logic                        timer_reg, timer_next;
    logic                        rev_reg, rev_next;
    logic                        cont_reg, cont_next;
    logic [sps_pkg::COUNT_W-1:0] steps_reg, steps_next;
    logic [2:0]                  sel_reg, sel_next;
    logic [7:0]                  cmp_reg, cmp_next;
    logic [sps_pkg::PSC_W-1:0]   psc_reg, psc_next;
    logic [7:0]                  per_reg, per_next;

    // Start request held while the divider runs
    logic                        hold_dir_reg, hold_dir_next;
    logic                        hold_cont_reg, hold_cont_next;
    logic                        hold_zero_reg, hold_zero_next;
    logic [sps_pkg::COUNT_W-1:0] hold_cnt_reg, hold_cnt_next;

    sps_pkg::rsp_t               rsp_reg, rsp_next;

    logic [sps_pkg::CLK_W-1:0]   quotient;
    logic                        div_done;
    sps_pkg::pick_t              pick;
    logic [2:0]                  idx_adv;
    logic [3:0]                  coil_adv;
    logic [sps_pkg::COUNT_W-1:0] steps_dec;
    logic                        accepted;
    logic                        stepped;

    sps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_begin),
        .rate     (req.step_rate),
        .quotient (quotient),
        .done     (div_done)
    );

    // Starts that pass the count check go through the divider
    assign status.needs_div = (req.req_type == sps_pkg::REQ_RUN) ||
                              (req.req_type == sps_pkg::REQ_MOVE &&
                               req.step_count != '0);
    assign status.div_done  = div_done;

    assign pick = sps_pkg::pick_rate(quotient, hold_zero_reg);

    // Next phase with wrap over eight or four entries
    always_comb
    begin
        if (half_reg) begin
            idx_adv  = rev_reg ? phase_reg - 3'd1 : phase_reg + 3'd1;
            coil_adv = sps_pkg::HALF_TABLE[idx_adv];
        end else begin
            idx_adv  = {1'b0, rev_reg ? phase_reg[1:0] - 2'd1 : phase_reg[1:0] + 2'd1};
            coil_adv = sps_pkg::FULL_TABLE[idx_adv[1:0]];
        end
    end

    // Apply the present item
    always_comb
    begin
        half_next      = half_reg;
        phase_next     = phase_reg;
        coil_next      = coil_reg;
        run_next       = run_reg;
        timer_next     = timer_reg;
        rev_next       = rev_reg;
        cont_next      = cont_reg;
        steps_next     = steps_reg;
        sel_next       = sel_reg;
        cmp_next       = cmp_reg;
        psc_next       = psc_reg;
        per_next       = per_reg;
        hold_dir_next  = hold_dir_reg;
        hold_cont_next = hold_cont_reg;
        hold_zero_next = hold_zero_reg;
        hold_cnt_next  = hold_cnt_reg;
        accepted       = 1'b1;
        stepped        = 1'b0;
        steps_dec      = (steps_reg != '0) ? steps_reg - sps_pkg::COUNT_W'(1) : steps_reg;

        if (cmd.apply) begin
            case (req.req_type)
                sps_pkg::REQ_TICK:
                begin
                    if (timer_reg) begin
                        if ({1'b0, psc_reg} + (sps_pkg::PSC_W+1)'(1) >=
                            sps_pkg::psc_ratio(sel_reg)) begin
                            psc_next = '0;
                            // Timer clock: count the period, step at its end
                            if (per_reg == cmp_reg) begin
                                per_next = '0;
                                if (run_reg) begin
                                    phase_next = idx_adv;
                                    coil_next  = coil_adv;
                                    stepped    = 1'b1;
                                    if (!cont_reg) begin
                                        steps_next = steps_dec;
                                        if (steps_dec == '0) begin
                                            timer_next = 1'b0;
                                            run_next   = 1'b0;
                                        end
                                    end
                                end
                            end else begin
                                per_next = per_reg + 8'd1;
                            end
                        end else begin
                            psc_next = psc_reg + sps_pkg::PSC_W'(1);
                        end
                    end
                end
                sps_pkg::REQ_STOP:
                begin
                    timer_next = 1'b0;
                    run_next   = 1'b0;
                    cont_next  = 1'b0;
                    steps_next = '0;
                    if (req.free_coils) begin
                        coil_next = 4'h0;
                    end
                end
                default:
                begin
                    // Counted move of zero steps: drop it
                    accepted = 1'b0;
                end
            endcase
        end

        // Latch the start and stop the timer while the divider runs
        if (cmd.start_begin) begin
            hold_dir_next  = req.direction;
            hold_cont_next = (req.req_type == sps_pkg::REQ_RUN);
            hold_zero_next = (req.step_rate == '0);
            hold_cnt_next  = req.step_count;
            timer_next     = 1'b0;
            psc_next       = '0;
            per_next       = '0;
        end

        // Arm the timer if a prescaler fits, else leave the run state alone
        if (cmd.start_finish) begin
            if (pick.ok) begin
                rev_next   = hold_dir_reg;
                steps_next = hold_cont_reg ? '0 : hold_cnt_reg;
                cont_next  = hold_cont_reg;
                run_next   = 1'b1;
                timer_next = 1'b1;
                sel_next   = pick.sel;
                cmp_next   = pick.cmp;
            end else begin
                accepted = 1'b0;
            end
        end

        if (cfg_we) begin
            half_next  = cfg_wdata;
            phase_next = 3'd0;
        end

        rsp_next = rsp_reg;
        if (cmd.apply || cmd.start_finish) begin
            rsp_next.coil_pattern = coil_next;
            rsp_next.accepted     = accepted;
            rsp_next.running      = run_next;
            rsp_next.steps_to_go  = steps_next;
            rsp_next.step_taken   = stepped;
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_reg      <= 1'b1;
            phase_reg     <= 3'd0;
            coil_reg      <= 4'h0;
            run_reg       <= 1'b0;
            timer_reg     <= 1'b0;
            rev_reg       <= 1'b0;
            cont_reg      <= 1'b0;
            steps_reg     <= '0;
            sel_reg       <= 3'd0;
            cmp_reg       <= 8'd0;
            psc_reg       <= '0;
            per_reg       <= 8'd0;
            hold_dir_reg  <= 1'b0;
            hold_cont_reg <= 1'b0;
            hold_zero_reg <= 1'b0;
            hold_cnt_reg  <= '0;
        end else begin
            half_reg      <= half_next;
            phase_reg     <= phase_next;
            coil_reg      <= coil_next;
            run_reg       <= run_next;
            timer_reg     <= timer_next;
            rev_reg       <= rev_next;
            cont_reg      <= cont_next;
            steps_reg     <= steps_next;
            sel_reg       <= sel_next;
            cmp_reg       <= cmp_next;
            psc_reg       <= psc_next;
            per_reg       <= per_next;
            hold_dir_reg  <= hold_dir_next;
            hold_cont_reg <= hold_cont_next;
            hold_zero_reg <= hold_zero_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

    // Result register, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp            = rsp_reg;
    assign half_step_mode = half_reg;

endmodule

FILE: sv/stepper_phase_sequencer.sv
// Stepper phase sequencer for a four-coil unipolar motor.
// Channels: req (sink) carries ticks, move/run starts and stops; rsp (source)
// returns one result beat per request beat: coil drive, accepted, running,
// remaining steps and whether a step was taken.
// Ticks and stops are applied directly: the result is valid the cycle after the
// request beat, and a new request is taken every cycle while rsp keeps up.
// A start that passes the count check waits for the bit-serial divider that
// works out CLOCK_HZ / rate one quotient bit a cycle, and req.ready stays
// low meanwhile.
// When rsp stalls, the result register holds and req.ready drops until the
// beat is taken; one result is in flight at most.
// APB port: register 0 (half_step_mode) at byte address 0; writing it resets
// the phase index. pready is always high.
// Reset (rst_n low, asynchronous) gives half-step mode, coils off, stopped.
// Depends on sps_pkg, sps_if, sps_ctrl, sps_datapath and sps_div.
module stepper_phase_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    sps_req_if.sink                     req,
    sps_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sps_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    sps_pkg::cmd_t    cmd;
    sps_pkg::status_t status;
    logic             cfg_we;
    logic             half_step_mode;

    // Decode the APB write to the mode register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr[2] == sps_pkg::REG_HALF_STEP);
    assign prdata = (paddr[2] == sps_pkg::REG_HALF_STEP) ?
                    {31'd0, half_step_mode} : 32'd0;

    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req            (req.payload),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[0]),
        .half_step_mode (half_step_mode),
        .status         (status),
        .rsp            (rsp.payload)
    );

    // Requests are taken only when the result slot can receive the beat
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!rsp.valid || rsp.ready))
        else $error("request taken while result slot is occupied");

    // A tick is answered in the next cycle
    a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.payload.req_type == sps_pkg::REQ_TICK)
        |=> rsp.valid)
        else $error("tick result not presented in the next cycle");

    // A step always leaves some coil energised
    a_step_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.step_taken) |-> (rsp.payload.coil_pattern != 4'h0))
        else $error("step taken with all coils off");

endmodule
